### hdl/swarq_pkg.sv
// Types, codes and reset values shared by the stop-and-wait ARQ link.
// Used by swarq_engine and stop_and_wait_arq_link; depends on nothing.

package swarq_pkg;

	// Event codes carried in the func field
	typedef enum logic [1:0] {
		FUNC_TICK  = 2'd0,
		FUNC_FRAME = 2'd1,
		FUNC_SEND  = 2'd2
	} swarq_func_t;

	// Result action codes
	typedef enum logic [1:0] {
		ACT_NONE     = 2'd0,
		ACT_TRANSMIT = 2'd1,
		ACT_FORWARD  = 2'd2
	} swarq_action_t;

	// Configuration register indexes (byte address = 4 * index)
	localparam logic [2:0] REG_TIMEOUT_TICKS  = 3'd0;
	localparam logic [2:0] REG_PAYLOAD_LENGTH = 3'd1;
	localparam logic [2:0] REG_DESTINATION_ID = 3'd2;
	localparam logic [2:0] REG_DATA_CODE      = 3'd3;
	localparam logic [2:0] REG_ACK_CODE       = 3'd4;

	localparam int unsigned PADDR_W = 5;

	// Register reset values
	localparam logic [15:0] TIMEOUT_RST = 16'd1000;
	localparam logic [4:0]  PAYLOAD_RST = 5'd31;
	localparam logic [7:0]  DEST_RST    = 8'd0;
	localparam logic [3:0]  DCODE_RST   = 4'd0;
	localparam logic [3:0]  ACODE_RST   = 4'd1;

	// One event transaction
	typedef struct packed {
		logic [1:0] func;
		logic [7:0] rx_header;
		logic [5:0] rx_length;
		logic       data_waiting;
		logic       send_space_ok;
		logic       link_paused;
		logic       tx_buffer_nonempty;
	} swarq_evt_t;

	// One result transaction
	typedef struct packed {
		logic [1:0] action;
		logic [7:0] frame_header;
		logic [5:0] frame_length;
		logic [7:0] frame_destination;
		logic       pop_buffer;
		logic       handling_needed;
	} swarq_res_t;

	// Configuration register set
	typedef struct packed {
		logic [15:0] timeout_ticks;
		logic [4:0]  payload_length;
		logic [7:0]  destination_id;
		logic [3:0]  data_code;
		logic [3:0]  ack_code;
	} swarq_cfg_t;

endpackage

### hdl/stop_and_wait_arq_link.sv
// Top level of the stop-and-wait ARQ link: event and result stages, config port.
// Depends on swarq_pkg and swarq_engine.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+------------------------------
//   event    | evt_valid / evt_stall | evt_data  (swarq_evt_t)
//   result   | res_valid / res_stall | res_data  (swarq_res_t)
//   config   | psel/penable/pwrite   | paddr, pwdata, prdata, pready
//
// One event per cycle while res_stall does not hold the flow; an accepted event
// passes the input register, one pass of logic and the result register to res_data.
// Reset clears the link state and loads the register defaults; no clearing pass.
// A stall on the result side holds the result register and then the input
// register; evt_stall rises only when both are full.

module stop_and_wait_arq_link #(
	parameter int unsigned MAX_PAYLOAD = 31
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               evt_valid,
	output logic                               evt_stall,
	input  swarq_pkg::swarq_evt_t              evt_data,
	output logic                               res_valid,
	input  logic                               res_stall,
	output swarq_pkg::swarq_res_t              res_data,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [swarq_pkg::PADDR_W-1:0]      paddr,
	input  logic [31:0]                        pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready
);

	swarq_pkg::swarq_cfg_t cfg_q;
	swarq_pkg::swarq_evt_t evt_s1;
	swarq_pkg::swarq_res_t res_s2;
	swarq_pkg::swarq_res_t res_d;
	logic                  valid_s1;
	logic                  valid_s2;
	logic                  adv_s1;
	logic                  load_s1;
	logic                  cfg_wr;
	logic [2:0]            reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout_ticks  <= swarq_pkg::TIMEOUT_RST;
			cfg_q.payload_length <= swarq_pkg::PAYLOAD_RST;
			cfg_q.destination_id <= swarq_pkg::DEST_RST;
			cfg_q.data_code      <= swarq_pkg::DCODE_RST;
			cfg_q.ack_code       <= swarq_pkg::ACODE_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				swarq_pkg::REG_TIMEOUT_TICKS:  cfg_q.timeout_ticks  <= pwdata[15:0];
				swarq_pkg::REG_PAYLOAD_LENGTH: cfg_q.payload_length <= pwdata[4:0];
				swarq_pkg::REG_DESTINATION_ID: cfg_q.destination_id <= pwdata[7:0];
				swarq_pkg::REG_DATA_CODE:      cfg_q.data_code      <= pwdata[3:0];
				swarq_pkg::REG_ACK_CODE:       cfg_q.ack_code       <= pwdata[3:0];
				default: begin
				end
			endcase
		end
	end

	// Read back configuration registers
	always_comb begin
		case (reg_idx)
			swarq_pkg::REG_TIMEOUT_TICKS:  prdata = {16'd0, cfg_q.timeout_ticks};
			swarq_pkg::REG_PAYLOAD_LENGTH: prdata = {27'd0, cfg_q.payload_length};
			swarq_pkg::REG_DESTINATION_ID: prdata = {24'd0, cfg_q.destination_id};
			swarq_pkg::REG_DATA_CODE:      prdata = {28'd0, cfg_q.data_code};
			swarq_pkg::REG_ACK_CODE:       prdata = {28'd0, cfg_q.ack_code};
			default:                       prdata = '0;
		endcase
	end

	// Advance when the result register is empty or being taken
	assign adv_s1    = valid_s1 && (!valid_s2 || !res_stall);
	assign evt_stall = valid_s1 && !adv_s1;
	assign load_s1   = evt_valid && !evt_stall;

	swarq_engine #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv_s1),
		.evt    (evt_s1),
		.cfg    (cfg_q),
		.res    (res_d)
	);

	// Track stage occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
			end else if (!res_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Capture the event and the result transactions
	always_ff @(posedge clk) begin
		if (load_s1) begin
			evt_s1 <= evt_data;
		end
		if (adv_s1) begin
			res_s2 <= res_d;
		end
	end

	assign res_valid = valid_s2;
	assign res_data  = res_s2;

endmodule

### hdl/swarq_engine.sv
// Protocol state of the stop-and-wait link and the single-pass event logic.
// Depends on swarq_pkg; instantiated by stop_and_wait_arq_link.

module swarq_engine #(
	parameter int unsigned MAX_PAYLOAD = 31
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  swarq_pkg::swarq_evt_t evt,
	input  swarq_pkg::swarq_cfg_t cfg,
	output swarq_pkg::swarq_res_t res
);

	localparam logic [7:0] MaxPay = 8'(MAX_PAYLOAD);

	logic        running_q;
	logic [15:0] count_q;
	logic [3:0]  seq_q;
	logic        first_q;
	logic [7:0]  pend_q;

	logic        running_d;
	logic [15:0] count_d;
	logic [3:0]  seq_d;
	logic        first_d;
	logic [7:0]  pend_d;

	logic [15:0] count_inc;
	logic [3:0]  rx_seq;
	logic [3:0]  rx_code;
	logic [5:0]  rx_pay;
	logic [5:0]  fwd_len;
	logic [4:0]  tx_pay;
	logic        fwd;

	// Work out the next state and the result for the event in hand
	always_comb begin
		running_d = running_q;
		count_d   = count_q;
		seq_d     = seq_q;
		first_d   = first_q;
		pend_d    = pend_q;
		fwd       = 1'b0;
		res       = '0;

		count_inc = count_q + 16'd1;
		rx_seq    = evt.rx_header[7:4];
		rx_code   = evt.rx_header[3:0];
		rx_pay    = (evt.rx_length == 6'd0) ? 6'd0 : evt.rx_length - 6'd1;
		fwd_len   = ({2'b00, rx_pay} > MaxPay) ? MaxPay[5:0] : rx_pay;
		tx_pay    = ({3'b000, cfg.payload_length} > MaxPay) ? MaxPay[4:0]
			: cfg.payload_length;

		case (evt.func)
			swarq_pkg::FUNC_TICK: begin
				// advance the retransmit timer, stop it on expiry
				if (running_q) begin
					if (count_inc == cfg.timeout_ticks) begin
						count_d   = '0;
						running_d = 1'b0;
					end else begin
						count_d = count_inc;
					end
				end
			end
			swarq_pkg::FUNC_FRAME: begin
				if (rx_code == cfg.data_code) begin
					// store the ack, forward unless a repeat
					pend_d  = {rx_seq, cfg.ack_code};
					first_d = 1'b1;
					fwd     = !first_q || (rx_seq != seq_q);
					if (fwd) begin
						seq_d            = rx_seq;
						res.action       = swarq_pkg::ACT_FORWARD;
						res.frame_length = fwd_len;
					end
				end else if (rx_code == cfg.ack_code) begin
					// matching ack: flip the sequence bit, drop the front set if there is one
					if (rx_seq == seq_q) begin
						seq_d = {3'b000, ~seq_q[0]};
						if (evt.tx_buffer_nonempty) begin
							res.pop_buffer = 1'b1;
							running_d      = 1'b0;
							count_d        = '0;
						end
					end
				end
			end
			swarq_pkg::FUNC_SEND: begin
				res.action            = swarq_pkg::ACT_TRANSMIT;
				res.frame_destination = cfg.destination_id;
				if (pend_q != 8'd0) begin
					res.frame_header = pend_q;
					res.frame_length = 6'd1;
					pend_d           = '0;
				end else begin
					res.frame_header = {seq_q, cfg.data_code};
					res.frame_length = {1'b0, tx_pay} + 6'd1;
					running_d        = 1'b1;
				end
			end
			default: begin
			end
		endcase

		res.handling_needed = (evt.data_waiting && !running_d)
			|| (evt.send_space_ok && (pend_d != 8'd0) && !evt.link_paused);
	end

	// Commit the state when the event leaves for the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			count_q   <= '0;
			seq_q     <= '0;
			first_q   <= 1'b0;
			pend_q    <= '0;
		end else if (step) begin
			running_q <= running_d;
			count_q   <= count_d;
			seq_q     <= seq_d;
			first_q   <= first_d;
			pend_q    <= pend_d;
		end
	end

endmodule
